[hw/rtl/gsd_pkg.sv]
// ============================================================================
// gsd_pkg: shared types and constants of the gyro stillness detector
// Sizes of the item fields, the window and the calibration divider, the item
// and status codes, and the Q15.16 helpers used by the top level.
// ============================================================================
`default_nettype none

package gsd_pkg;

   localparam int WINDOW      = 16;
   localparam int CAL_SAMPLES = 10;

   localparam int RATE_W      = 32;
   localparam int BOUND_W     = 38;
   localparam int BAIL_W      = 16;
   localparam int COUNT_W     = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 38;

   // one window slot holds the sum of three axis magnitudes (each up to 2^31)
   localparam int SLOT_W  = 33;
   localparam int SUM_W   = $clog2(WINDOW) + SLOT_W;
   localparam int CMP_W   = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;

   // calibration accumulator and digit-serial divider
   localparam int CSUM_W    = 36;
   localparam int CALCNT_W  = 4;
   localparam int DIGIT_W   = 4;
   localparam int REM_W     = 4;
   localparam int DIV_STEPS = CSUM_W / DIGIT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int ONE_Q16 = 65536;
   localparam logic [SLOT_W-1:0]   SLOT_RELOAD = SLOT_W'(3 * ONE_Q16);
   localparam logic [SUM_W-1:0]    SUM_RELOAD  = SUM_W'(3 * ONE_Q16);
   localparam logic [BOUND_W-1:0]  BOUND_RESET = BOUND_W'(ONE_Q16);
   localparam logic [BAIL_W-1:0]   BAIL_RESET  = BAIL_W'(1000);
   localparam logic [CALCNT_W-1:0] CAL_LAST    = CALCNT_W'(CAL_SAMPLES);

   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_BOUNDARY = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BAIL_LIMIT     = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      KIND_CAL_START   = 2'd0,
      KIND_CAL_SAMPLE  = 2'd1,
      KIND_WAIT_START  = 2'd2,
      KIND_WAIT_SAMPLE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_STILL        = 3'd0,
      ST_MOVING       = 3'd1,
      ST_TIMEOUT      = 3'd2,
      ST_SENSOR_ERROR = 3'd3,
      ST_IDLE         = 3'd4,
      ST_CALIBRATING  = 3'd5,
      ST_CAL_DONE     = 3'd6,
      ST_STARTED      = 3'd7
   } status_type;

   typedef struct packed {
      logic start;
      logic sample;
      logic sensor_error;
   } cal_ctl_type;

   typedef struct packed {
      logic       busy;
      status_type status;
   } cal_resp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } win_ctl_type;

   // rate minus offset, saturated to 32 bits
   function automatic logic signed [RATE_W-1:0] sat_dev(input logic signed [RATE_W:0] v);
      logic signed [RATE_W-1:0] r;
      if (v[RATE_W] != v[RATE_W-1]) begin
         r = v[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
      end else begin
         r = v[RATE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [RATE_W-1:0] mag(input logic signed [RATE_W-1:0] v);
      logic [RATE_W-1:0] r;
      r = v[RATE_W-1] ? (~v + RATE_W'(1)) : v;
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/gyro_stillness_detector_top.sv]
// Accepted items go through the stage 1, stage 2 and output registers to rsp.
// Throughput: one item per cycle through three pipeline stages while not stalled.
// After the calibration sample that completes a calibration, req_stall stays high
// while the offset divider runs one 4-bit digit per cycle.
// Reset (synchronous, active high) empties the pipeline, idles calibration and
// waiting, clears the offsets and loads the register defaults.
// ============================================================================
// gyro_stillness_detector_top: three-axis gyro stillness detector
// Offset calibration, offset-corrected deviations and a window of slot cells
// carrying the absolute running sum checked against the stillness boundary.
// ============================================================================
`default_nettype none

module gyro_stillness_detector_top
   import gsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_kind,
   input  wire logic signed [RATE_W-1:0] req_rate_x,
   input  wire logic signed [RATE_W-1:0] req_rate_y,
   input  wire logic signed [RATE_W-1:0] req_rate_z,
   input  wire logic                     req_sensor_error,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [BOUND_W-1:0]            rsp_window_sum,
   output logic [COUNT_W-1:0]            rsp_sample_count,

   input  wire logic                     csr_write,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   logic [BOUND_W-1:0]        boundary_ff;
   logic [BAIL_W-1:0]         bail_ff;

   cal_ctl_type               cal_ctl;
   cal_resp_type              cal_resp;
   logic signed [RATE_W-1:0]  offset [3];
   logic signed [RATE_W-1:0]  rate   [3];
   logic signed [RATE_W-1:0]  dev    [3];
   kind_type                  req_kind_e;
   logic                      req_fire;

   logic                      s1_valid_ff;
   kind_type                  s1_kind_ff;
   logic                      s1_err_ff;
   status_type                s1_status_ff;
   logic signed [RATE_W-1:0]  s1_dev_ff [3];

   logic                      s2_valid_ff;
   kind_type                  s2_kind_ff;
   logic                      s2_err_ff;
   status_type                s2_status_ff;
   logic [SLOT_W-1:0]         s2_msum_ff;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [BOUND_W-1:0]        rsp_window_sum_ff;
   logic [COUNT_W-1:0]        rsp_sample_count_ff;

   logic [SUM_W-1:0]          sum_ff;
   logic [SUM_W-1:0]          sum_in;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic                      waiting_ff;
   logic                      waiting_in;
   status_type                status_in;
   logic [SUM_W-1:0]          new_sum;
   logic [CMP_W-1:0]          sum_wide;
   logic [BOUND_W-1:0]        window_sum_in;

   win_ctl_type               win_ctl;
   logic [SLOT_W-1:0]         cell_value [WINDOW];

   logic                      out_free;
   logic                      s2_free;
   logic                      s1_free;
   logic                      s1_move;
   logic                      s2_move;

   // ---------------------------------------------------------------- handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s2_move   = s2_valid_ff && out_free;
   assign req_stall = !s1_free || cal_resp.busy;
   assign req_fire  = req_valid && !req_stall;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_ff <= BOUND_RESET;
         bail_ff     <= BAIL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STILL_BOUNDARY: boundary_ff <= csr_data[BOUND_W-1:0];
            CSR_BAIL_LIMIT:     bail_ff     <= csr_data[BAIL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- calibration
   assign req_kind_e           = kind_type'(req_kind);
   assign cal_ctl.start        = req_fire && (req_kind_e == KIND_CAL_START);
   assign cal_ctl.sample       = req_fire && (req_kind_e == KIND_CAL_SAMPLE);
   assign cal_ctl.sensor_error = req_sensor_error;

   gsd_cal u_cal (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cal_ctl),
      .rate_x (req_rate_x),
      .rate_y (req_rate_y),
      .rate_z (req_rate_z),
      .resp   (cal_resp),
      .offset (offset)
   );

   // ---------------------------------------------------------------- stage 1
   assign rate[0] = req_rate_x;
   assign rate[1] = req_rate_y;
   assign rate[2] = req_rate_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dev[a] = sat_dev((RATE_W+1)'(rate[a]) - (RATE_W+1)'(offset[a]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= req_kind_e;
         s1_err_ff    <= req_sensor_error;
         s1_status_ff <= cal_resp.status;
         for (int a = 0; a < 3; a++) begin
            s1_dev_ff[a] <= dev[a];
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_err_ff    <= s1_err_ff;
         s2_status_ff <= s1_status_ff;
         s2_msum_ff   <= SLOT_W'(mag(s1_dev_ff[0])) + SLOT_W'(mag(s1_dev_ff[1]))
                       + SLOT_W'(mag(s1_dev_ff[2]));
      end
   end

   // ---------------------------------------------------------------- window
   generate
      for (genvar k = 0; k < WINDOW; k++) begin : g_cell
         if (k == WINDOW - 1) begin : g_tail
            gsd_cell u_cell (
               .clock      (clock),
               .ctl        (win_ctl),
               .load_value (SLOT_RELOAD),
               .shift_in   (s2_msum_ff),
               .value      (cell_value[k])
            );
         end else begin : g_body
            gsd_cell u_cell (
               .clock      (clock),
               .ctl        (win_ctl),
               .load_value ({SLOT_W{1'b0}}),
               .shift_in   (cell_value[k+1]),
               .value      (cell_value[k])
            );
         end
      end
   endgenerate

   // head cell is the slot the next wait sample replaces
   assign new_sum = sum_ff - SUM_W'(cell_value[0]) + SUM_W'(s2_msum_ff);

   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      waiting_in    = waiting_ff;
      status_in     = s2_status_ff;
      win_ctl.load  = 1'b0;
      win_ctl.shift = 1'b0;
      if (s2_move) begin
         unique case (s2_kind_ff) inside
            KIND_CAL_START, KIND_CAL_SAMPLE: ;
            KIND_WAIT_START: begin
               win_ctl.load = 1'b1;
               sum_in       = SUM_RELOAD;
               count_in     = '0;
               waiting_in   = 1'b1;
               status_in    = ST_STARTED;
            end
            KIND_WAIT_SAMPLE: begin
               if (!waiting_ff) begin
                  status_in = ST_IDLE;
               end else if (s2_err_ff) begin
                  waiting_in = 1'b0;
                  status_in  = ST_SENSOR_ERROR;
               end else begin
                  sum_in = new_sum;
                  if (CMP_W'(new_sum) < CMP_W'(boundary_ff)) begin
                     waiting_in = 1'b0;
                     status_in  = ST_STILL;
                  end else if (count_ff > COUNT_W'(bail_ff)) begin
                     waiting_in = 1'b0;
                     status_in  = ST_TIMEOUT;
                  end else begin
                     win_ctl.shift = 1'b1;
                     count_in      = count_ff + COUNT_W'(1);
                     status_in     = ST_MOVING;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign sum_wide      = CMP_W'(sum_in);
   assign window_sum_in = (sum_wide > CMP_W'({BOUND_W{1'b1}})) ? {BOUND_W{1'b1}}
                                                               : sum_wide[BOUND_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= SUM_RELOAD;
         count_ff   <= '0;
         waiting_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         waiting_ff <= waiting_in;
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_status_ff       <= status_in;
         rsp_window_sum_ff   <= window_sum_in;
         rsp_sample_count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_window_sum   = rsp_window_sum_ff;
   assign rsp_sample_count = rsp_sample_count_ff;

endmodule

`default_nettype wire

[hw/rtl/gsd_cell.sv]
// ============================================================================
// gsd_cell: one slot of the deviation window
// Holds the summed axis magnitudes of one slot; reloads, or takes its shift input
// (the neighbor's value, or the new sample in the tail cell) when the window advances.
// ============================================================================
`default_nettype none

module gsd_cell
   import gsd_pkg::*;
(
   input  wire logic              clock,
   input  wire win_ctl_type       ctl,
   input  wire logic [SLOT_W-1:0] load_value,
   input  wire logic [SLOT_W-1:0] shift_in,
   output logic      [SLOT_W-1:0] value
);

   logic [SLOT_W-1:0] value_ff;
   logic [SLOT_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = load_value;
      end else if (ctl.shift) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[hw/rtl/gsd_cal.sv]
// ============================================================================
// gsd_cal: calibration accumulator and offset divider
// Sums calibration samples per axis and divides the sums by the sample count,
// one 4-bit digit per cycle on three lanes, truncating toward zero.
// ============================================================================
`default_nettype none

module gsd_cal
   import gsd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cal_ctl_type              ctl,
   input  wire logic signed [RATE_W-1:0] rate_x,
   input  wire logic signed [RATE_W-1:0] rate_y,
   input  wire logic signed [RATE_W-1:0] rate_z,
   output cal_resp_type                  resp,
   output logic signed [RATE_W-1:0]      offset [3]
);

   function automatic logic [REM_W+DIGIT_W-1:0] div_digit(input logic [REM_W-1:0]   rem,
                                                           input logic [DIGIT_W-1:0] bits);
      logic [REM_W:0]     r;
      logic [DIGIT_W-1:0] q;
      r = {1'b0, rem};
      q = '0;
      for (int b = DIGIT_W - 1; b >= 0; b--) begin
         r = {r[REM_W-1:0], bits[b]};
         if (r >= (REM_W+1)'(CAL_SAMPLES)) begin
            r    = r - (REM_W+1)'(CAL_SAMPLES);
            q[b] = 1'b1;
         end
      end
      return {r[REM_W-1:0], q};
   endfunction

   logic                       active_ff;
   logic                       busy_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [CALCNT_W-1:0]        count_ff;
   logic signed [CSUM_W-1:0]   sum_ff     [3];
   logic signed [RATE_W-1:0]   offset_ff  [3];
   logic [CSUM_W-1:0]          div_mag_ff [3];
   logic                       div_neg_ff [3];
   logic [CSUM_W-1:0]          quo_ff     [3];
   logic [REM_W-1:0]           rem_ff     [3];

   logic signed [RATE_W-1:0]   rate       [3];
   logic signed [CSUM_W-1:0]   sum_in     [3];
   logic [CSUM_W-1:0]          mag_in     [3];
   logic [REM_W+DIGIT_W-1:0]   digit      [3];
   logic [CSUM_W-1:0]          quo_in     [3];
   logic [CALCNT_W-1:0]        count_in;
   logic                       take;
   logic                       last;

   assign rate[0] = rate_x;
   assign rate[1] = rate_y;
   assign rate[2] = rate_z;

   assign take     = ctl.sample && active_ff && !ctl.sensor_error;
   assign count_in = count_ff + CALCNT_W'(1);
   assign last     = count_in >= CAL_LAST;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = sum_ff[a] + CSUM_W'(rate[a]);
         mag_in[a] = sum_in[a][CSUM_W-1] ? (CSUM_W'(0) - sum_in[a]) : sum_in[a];
         digit[a]  = div_digit(rem_ff[a], div_mag_ff[a][CSUM_W-1 -: DIGIT_W]);
         quo_in[a] = {quo_ff[a][CSUM_W-DIGIT_W-1:0], digit[a][DIGIT_W-1:0]};
      end
   end

   always_comb begin
      resp.busy   = busy_ff;
      resp.status = ST_IDLE;
      if (ctl.start) begin
         resp.status = ST_CALIBRATING;
      end else if (ctl.sample && active_ff) begin
         if (ctl.sensor_error) begin
            resp.status = ST_SENSOR_ERROR;
         end else if (last) begin
            resp.status = ST_CAL_DONE;
         end else begin
            resp.status = ST_CALIBRATING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         busy_ff   <= 1'b0;
         step_ff   <= '0;
         count_ff  <= '0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a]    <= '0;
            offset_ff[a] <= '0;
         end
      end else begin
         if (ctl.start) begin
            active_ff <= 1'b1;
            count_ff  <= '0;
            for (int a = 0; a < 3; a++) begin
               sum_ff[a]    <= '0;
               offset_ff[a] <= '0;
            end
         end else if (take) begin
            count_ff <= count_in;
            for (int a = 0; a < 3; a++) begin
               sum_ff[a] <= sum_in[a];
            end
            if (last) begin
               active_ff <= 1'b0;
               busy_ff   <= 1'b1;
               step_ff   <= STEP_W'(DIV_STEPS - 1);
            end
         end
         if (busy_ff) begin
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               for (int a = 0; a < 3; a++) begin
                  offset_ff[a] <= $signed(RATE_W'(div_neg_ff[a] ? (CSUM_W'(0) - quo_in[a])
                                                                : quo_in[a]));
               end
            end else begin
               step_ff <= step_ff - STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (take && last) begin
            div_mag_ff[a] <= mag_in[a];
            div_neg_ff[a] <= sum_in[a][CSUM_W-1];
            quo_ff[a]     <= '0;
            rem_ff[a]     <= '0;
         end else if (busy_ff) begin
            div_mag_ff[a] <= div_mag_ff[a] << DIGIT_W;
            quo_ff[a]     <= quo_in[a];
            rem_ff[a]     <= digit[a][REM_W+DIGIT_W-1:DIGIT_W];
         end
      end
   end

   assign offset = offset_ff;

endmodule

`default_nettype wire

[hw/rtl/gsd_checker.sv]
// ============================================================================
// gsd_checker: port-level checks of the gyro stillness detector
// Watches the top-level ports over time; attached to the top level by bind.
// ============================================================================
`default_nettype none

module gsd_checker
   import gsd_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [1:0]               req_kind,
   input wire logic signed [RATE_W-1:0] req_rate_x,
   input wire logic signed [RATE_W-1:0] req_rate_y,
   input wire logic signed [RATE_W-1:0] req_rate_z,
   input wire logic                     req_sensor_error,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [2:0]               rsp_status,
   input wire logic [BOUND_W-1:0]       rsp_window_sum,
   input wire logic [COUNT_W-1:0]       rsp_sample_count,
   input wire logic                     csr_write,
   input wire logic [CSR_INDEX_W-1:0]   csr_index,
   input wire logic [CSR_DATA_W-1:0]    csr_data
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_window_sum) && $stable(rsp_sample_count))
      else $error("stalled result changed");

   a_start_reload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_STARTED) |->
         (rsp_window_sum == BOUND_W'(3 * ONE_Q16)) && (rsp_sample_count == '0))
      else $error("wait start did not reload window sum and count");

   a_moving_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MOVING) |-> (rsp_sample_count != '0))
      else $error("moving result with zero sample count");

endmodule

bind gyro_stillness_detector_top gsd_checker u_gsd_checker (.*);

`default_nettype wire
